// ----- rtl/sukl_pkg.sv -----
// shared types, widths and codes for the sorted unique key list
// no dependencies; used by the controller, the datapath, the top level and the checker
package sukl_pkg;

   localparam int KEY_W        = 32;
   localparam int OP_W         = 2;
   localparam int STATUS_W     = 3;
   localparam int COUNT_W      = 6;
   localparam int DEF_CAPACITY = 32;

   // request operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DUMP     = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture the request
      logic update;     // run insert or remove and emit its result
      logic dump_init;  // clear the dump index
      logic dump_step;  // emit cell zero and rotate the occupied cells
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            count_zero;
      logic            dump_last;
   } sts_type;

endpackage

// ----- rtl/sorted_unique_key_list.sv -----
// top level of the sorted unique key list: ports, controller and datapath
// depends on sukl_pkg, sukl_ctrl and sukl_datapath
// an insert/remove result is shown in the cycle after the execute cycle
// a dump shows one result per occupied cell on consecutive cycles, in ascending key
// order, the last one flagged; a dump of an empty list gives no result
// busy stays high through the execute cycle and the dump steps, so a new request waits
// until the last one is through
// reset: synchronous, clears count, controller and result strobe; no receiver stall
module sorted_unique_key_list #(
   parameter int CAPACITY = sukl_pkg::DEF_CAPACITY
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic [sukl_pkg::OP_W-1:0]         req_operation,
   input  logic signed [sukl_pkg::KEY_W-1:0] req_key,
   // result channel
   output logic                              rsp_strobe,
   output logic [sukl_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [sukl_pkg::KEY_W-1:0] rsp_entry_value,
   output logic [sukl_pkg::COUNT_W-1:0]      rsp_entry_count,
   output logic                              rsp_last
);
   import sukl_pkg::*;

   // command and status between the two halves
   cmd_type cmd;
   sts_type sts;

   // sequencing: idle, execute one request, then step through a dump
   sukl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // key cells, parallel compare, shifting and result registers
   sukl_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- rtl/sukl_ctrl.sv -----
// controller state machine for the sorted unique key list
// depends on sukl_pkg (cmd_type, sts_type, operation codes)
module sukl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sukl_pkg::sts_type sts,
   output sukl_pkg::cmd_type cmd
);
   import sukl_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   logic [1:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            if (sts.op == OP_INSERT || sts.op == OP_REMOVE) begin
               cmd.update = 1'b1;
            end else if (sts.op == OP_DUMP && !sts.count_zero) begin
               cmd.dump_init = 1'b1;
               state_in      = S_DUMP;
            end
         end
         S_DUMP: begin
            cmd.dump_step = 1'b1;
            if (sts.dump_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/sukl_datapath.sv -----
// key cells with parallel compare, shift insert/remove, rotating dump and result registers
// depends on sukl_pkg (cmd_type, sts_type, codes, widths)
module sukl_datapath #(
   parameter int CAPACITY = sukl_pkg::DEF_CAPACITY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sukl_pkg::cmd_type                 cmd,
   output sukl_pkg::sts_type                 sts,
   input  logic [sukl_pkg::OP_W-1:0]         req_operation,
   input  logic signed [sukl_pkg::KEY_W-1:0] req_key,
   output logic                              rsp_strobe,
   output logic [sukl_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [sukl_pkg::KEY_W-1:0] rsp_entry_value,
   output logic [sukl_pkg::COUNT_W-1:0]      rsp_entry_count,
   output logic                              rsp_last
);
   import sukl_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [OP_W-1:0]         op_ff, op_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic signed [KEY_W-1:0] cells_ff [CAPACITY];
   logic signed [KEY_W-1:0] cells_in [CAPACITY];

   logic                    strobe_ff, strobe_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic signed [KEY_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]        rcount_ff, rcount_in;
   logic                    last_ff, last_in;

   logic [CAPACITY-1:0]     less, eq, prev_less;
   logic signed [KEY_W-1:0] prev_cell [CAPACITY];
   logic signed [KEY_W-1:0] next_cell [CAPACITY];
   logic                    found, full, dump_last;

   // per-cell compare against the captured key, only for occupied cells
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         less[i] = (CNT_W'(i) < count_ff) && (cells_ff[i] < key_ff);
         eq[i]   = (CNT_W'(i) < count_ff) && (cells_ff[i] == key_ff);
      end
      prev_less[0] = 1'b1;
      prev_cell[0] = key_ff;
      for (int i = 1; i < CAPACITY; i++) begin
         prev_less[i] = less[i-1];
         prev_cell[i] = cells_ff[i-1];
      end
      for (int i = 0; i < CAPACITY - 1; i++) begin
         next_cell[i] = cells_ff[i+1];
      end
      next_cell[CAPACITY-1] = cells_ff[CAPACITY-1];
   end

   assign found     = |eq;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign dump_last = (idx_ff + CNT_W'(1) == count_ff);

   assign sts.op         = op_ff;
   assign sts.count_zero = (count_ff == '0);
   assign sts.dump_last  = dump_last;

   always_comb begin
      op_in     = op_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      cells_in  = cells_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      value_in  = value_ff;
      rcount_in = rcount_ff;
      last_in   = last_ff;

      if (cmd.load) begin
         op_in  = req_operation;
         key_in = req_key;
      end

      if (cmd.update) begin
         strobe_in = 1'b1;
         value_in  = key_ff;
         last_in   = 1'b1;
         if (op_ff == OP_INSERT) begin
            if (found) begin
               status_in = ST_DUP;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_INSERTED;
               count_in  = count_ff + CNT_W'(1);
               // first cell not below the key takes it, the rest move up
               for (int i = 0; i < CAPACITY; i++) begin
                  if (!less[i]) begin
                     cells_in[i] = prev_less[i] ? key_ff : prev_cell[i];
                  end
               end
            end
         end else begin
            if (found) begin
               status_in = ST_REMOVED;
               count_in  = count_ff - CNT_W'(1);
               for (int i = 0; i < CAPACITY; i++) begin
                  if (!less[i]) begin
                     cells_in[i] = next_cell[i];
                  end
               end
            end else begin
               status_in = ST_NOTFOUND;
            end
         end
         rcount_in = count_in;
      end

      if (cmd.dump_init) begin
         idx_in = '0;
      end

      if (cmd.dump_step) begin
         strobe_in = 1'b1;
         status_in = ST_DUMP;
         value_in  = cells_ff[0];
         rcount_in = count_ff;
         last_in   = dump_last;
         idx_in    = idx_ff + CNT_W'(1);
         // rotate occupied cells down by one; after count steps the order is back
         for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) + CNT_W'(1) < count_ff) begin
               cells_in[i] = next_cell[i];
            end else if (CNT_W'(i) + CNT_W'(1) == count_ff) begin
               cells_in[i] = cells_ff[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      cells_ff  <= cells_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      rcount_ff <= rcount_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_value = value_ff;
   assign rsp_entry_count = COUNT_W'(rcount_ff);
   assign rsp_last        = last_ff;

endmodule

// ----- rtl/sukl_checker.sv -----
// port-level checks for the sorted unique key list, bound to the top level
// depends on sukl_pkg (status codes, widths)
module sukl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_strobe,
   input logic [sukl_pkg::STATUS_W-1:0]     rsp_status,
   input logic                              rsp_last
);
   import sukl_pkg::*;

   // a taken request keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("not busy after request accepted");

   // insert and remove give a single result
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_DUMP |-> rsp_last)
      else $error("non-dump result without last");

   // a dump that has not ended goes on in the next cycle
   a_dump_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe && rsp_status == ST_DUMP)
      else $error("dump stream broken");

   // the final result of a request is followed by a gap
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("result right after last");

endmodule

bind sorted_unique_key_list sukl_checker u_sukl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_status (rsp_status),
   .rsp_last   (rsp_last)
);
